>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under the block clock and reset
`define AST_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("check failed: %m");

// next-cycle implication under the block clock and reset
`define AST_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("check failed: %m");

`endif

>>> design/acobm_pkg.sv
`timescale 1ns / 1ps

package acobm_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned GhostW = 8;
	localparam int unsigned ProdW  = 2 * CoordW;
	localparam int unsigned MeasW  = 3 * CoordW;
	localparam int unsigned CfgIdxW = 3;

	localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
	localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

	localparam logic [CfgIdxW-1:0] RegChildMinX = 3'd0;
	localparam logic [CfgIdxW-1:0] RegChildMaxX = 3'd1;
	localparam logic [CfgIdxW-1:0] RegChildMinY = 3'd2;
	localparam logic [CfgIdxW-1:0] RegChildMaxY = 3'd3;
	localparam logic [CfgIdxW-1:0] RegChildMinZ = 3'd4;
	localparam logic [CfgIdxW-1:0] RegChildMaxZ = 3'd5;
	localparam logic [CfgIdxW-1:0] RegVolumeMode = 3'd6;
	localparam logic [CfgIdxW-1:0] RegClearOldMark = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPAN,
		ST_MUL_OV,
		ST_MUL_CE,
		ST_OV_LO,
		ST_OV_HI,
		ST_SUM_OV,
		ST_CE_LO,
		ST_CE_HI,
		ST_SUM_CE,
		ST_DECIDE
	} state_t;

endpackage

>>> design/amr_cell_overlap_blank_marker.sv
// Cell blanking against one child box.
// Input stream (s_axis): one corner point of a mesh cell per transfer, s_axis_tlast
// on the final corner. The block grows the cell's bounding box from the points,
// and on the final corner intersects it with the child box held in the config
// registers, then compares twice the overlap area (volume_mode 0) or volume
// (volume_mode 1) with the cell's own measure.
// Output stream (s_axis -> m_axis): one transfer per cell carrying the updated
// ghost byte and the hit flag.
// Non-final corners are taken back to back while idle. A final corner holds
// s_axis_tready low through the span, multiply and compare states, and in
// volume mode also through the partial product and add states; the single 32x32
// multiplier forms all partial products one per cycle, one add per 96-bit measure.
// The result appears on m_axis the cycle after the compare.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; write them
// only while the block is idle.
// Reset clears the config registers to 0, empties the cell box and drops
// m_axis_tvalid. A stalled m_axis keeps its result; further corners are still
// taken, but the next cell waits in its compare cycle until the output is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amr_cell_overlap_blank_marker
	import acobm_pkg::*;
#(
	parameter int unsigned BLANK_BIT = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CoordW-1:0]    cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// point_x, point_y, point_z, ghost_in
	input  logic [3*CoordW+GhostW-1:0] s_axis_tdata,
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// ghost_out, overlap_hit, zero fill
	output logic [15:0]          m_axis_tdata
);

	function automatic logic signed [CoordW-1:0] smax(logic signed [CoordW-1:0] a,
			logic signed [CoordW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [CoordW-1:0] smin(logic signed [CoordW-1:0] a,
			logic signed [CoordW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [CoordW-1:0] span(logic signed [CoordW-1:0] lo,
			logic signed [CoordW-1:0] hi);
		logic [CoordW-1:0] d;
		d = CoordW'(hi - lo);
		return (hi < lo) ? '0 : d;
	endfunction

	logic signed [CoordW-1:0] child_min_x_q, child_max_x_q;
	logic signed [CoordW-1:0] child_min_y_q, child_max_y_q;
	logic signed [CoordW-1:0] child_min_z_q, child_max_z_q;
	logic                     volume_mode_q, clear_old_mark_q;

	logic signed [CoordW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, lo_z_q, hi_z_q;
	logic [CoordW-1:0]        ox_q, oy_q, oz_q, cx_q, cy_q, cz_q;
	logic [GhostW-1:0]        ghost_q;
	logic [ProdW-1:0]         pl_q, ph_q;
	logic [MeasW-1:0]         ov_q, ce_q;
	logic                     out_valid_q;
	logic [GhostW-1:0]        ghost_out_q;
	logic                     hit_q;

	state_t state_q, state_d;

	logic signed [CoordW-1:0] pt_x, pt_y, pt_z;
	logic [GhostW-1:0]        ghost_in;
	logic                     s_fire, out_free;
	logic [CoordW-1:0]        mul_a, mul_b;
	logic [ProdW-1:0]         mul_p;
	logic [MeasW-1:0]         sum_p;
	logic                     hit_d;
	logic [GhostW-1:0]        ghost_d;

	assign pt_x     = s_axis_tdata[CoordW-1:0];
	assign pt_y     = s_axis_tdata[2*CoordW-1:CoordW];
	assign pt_z     = s_axis_tdata[3*CoordW-1:2*CoordW];
	assign ghost_in = s_axis_tdata[3*CoordW+GhostW-1:3*CoordW];
	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// shared multiplier and partial product adder
	assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);
	assign sum_p = {ph_q, {CoordW{1'b0}}} + MeasW'(pl_q);

	assign hit_d = {ov_q, 1'b0} > {1'b0, ce_q};
	always_comb begin
		ghost_d = ghost_q;
		if (clear_old_mark_q) begin
			ghost_d[BLANK_BIT] = 1'b0;
		end
		if (hit_d) begin
			ghost_d[BLANK_BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			child_min_x_q    <= '0;
			child_max_x_q    <= '0;
			child_min_y_q    <= '0;
			child_max_y_q    <= '0;
			child_min_z_q    <= '0;
			child_max_z_q    <= '0;
			volume_mode_q    <= 1'b0;
			clear_old_mark_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegChildMinX:    child_min_x_q    <= cfg_data;
				RegChildMaxX:    child_max_x_q    <= cfg_data;
				RegChildMinY:    child_min_y_q    <= cfg_data;
				RegChildMaxY:    child_max_y_q    <= cfg_data;
				RegChildMinZ:    child_min_z_q    <= cfg_data;
				RegChildMaxZ:    child_max_z_q    <= cfg_data;
				RegVolumeMode:   volume_mode_q    <= cfg_data[0];
				RegClearOldMark: clear_old_mark_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// cell bounding box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_x_q <= CoordMax;
			hi_x_q <= CoordMin;
			lo_y_q <= CoordMax;
			hi_y_q <= CoordMin;
			lo_z_q <= CoordMax;
			hi_z_q <= CoordMin;
		end else if (state_q == ST_SPAN) begin
			lo_x_q <= CoordMax;
			hi_x_q <= CoordMin;
			lo_y_q <= CoordMax;
			hi_y_q <= CoordMin;
			lo_z_q <= CoordMax;
			hi_z_q <= CoordMin;
		end else if (s_fire) begin
			lo_x_q <= smin(lo_x_q, pt_x);
			hi_x_q <= smax(hi_x_q, pt_x);
			lo_y_q <= smin(lo_y_q, pt_y);
			hi_y_q <= smax(hi_y_q, pt_y);
			lo_z_q <= smin(lo_z_q, pt_z);
			hi_z_q <= smax(hi_z_q, pt_z);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_fire && s_axis_tlast) begin
			ghost_q <= ghost_in;
		end
		case (state_q)
			ST_SPAN: begin
				ox_q <= span(smax(lo_x_q, child_min_x_q), smin(hi_x_q, child_max_x_q));
				oy_q <= span(smax(lo_y_q, child_min_y_q), smin(hi_y_q, child_max_y_q));
				oz_q <= span(smax(lo_z_q, child_min_z_q), smin(hi_z_q, child_max_z_q));
				cx_q <= span(lo_x_q, hi_x_q);
				cy_q <= span(lo_y_q, hi_y_q);
				cz_q <= span(lo_z_q, hi_z_q);
			end
			ST_MUL_OV: ov_q <= MeasW'(mul_p);
			ST_MUL_CE: ce_q <= MeasW'(mul_p);
			ST_OV_LO:  pl_q <= mul_p;
			ST_OV_HI:  ph_q <= mul_p;
			ST_SUM_OV: ov_q <= sum_p;
			ST_CE_LO:  pl_q <= mul_p;
			ST_CE_HI:  ph_q <= mul_p;
			ST_SUM_CE: ce_q <= sum_p;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECIDE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && out_free) begin
			ghost_out_q <= ghost_d;
			hit_q       <= hit_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire && s_axis_tlast) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN:   state_d = ST_MUL_OV;
			ST_MUL_OV: state_d = ST_MUL_CE;
			ST_MUL_CE: state_d = volume_mode_q ? ST_OV_LO : ST_DECIDE;
			ST_OV_LO:  state_d = ST_OV_HI;
			ST_OV_HI:  state_d = ST_SUM_OV;
			ST_SUM_OV: state_d = ST_CE_LO;
			ST_CE_LO:  state_d = ST_CE_HI;
			ST_CE_HI:  state_d = ST_SUM_CE;
			ST_SUM_CE: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		s_axis_tready = 1'b0;
		mul_a         = ox_q;
		mul_b         = oy_q;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_MUL_OV: begin
				mul_a = ox_q;
				mul_b = oy_q;
			end
			ST_MUL_CE: begin
				mul_a = cx_q;
				mul_b = cy_q;
			end
			ST_OV_LO: begin
				mul_a = ov_q[CoordW-1:0];
				mul_b = oz_q;
			end
			ST_OV_HI: begin
				mul_a = ov_q[ProdW-1:CoordW];
				mul_b = oz_q;
			end
			ST_CE_LO: begin
				mul_a = ce_q[CoordW-1:0];
				mul_b = cz_q;
			end
			ST_CE_HI: begin
				mul_a = ce_q[ProdW-1:CoordW];
				mul_b = cz_q;
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, hit_q, ghost_out_q};

	`AST_IMP(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready)
	`AST_NXT(a_last_starts, s_fire && s_axis_tlast, state_q == ST_SPAN)
	`AST_NXT(a_box_cleared, state_q == ST_SPAN,
		lo_x_q == CoordMax && hi_x_q == CoordMin && lo_z_q == CoordMax)
	`AST_IMP(a_hit_sets_bit, m_axis_tvalid && m_axis_tdata[GhostW],
		m_axis_tdata[BLANK_BIT])

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top
	import acobm_pkg::*;
();

	localparam int unsigned BLANK_POS = 3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 20;

	typedef struct {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [CoordW-1:0] z;
		logic [GhostW-1:0] ghost;
		logic last;
	} corner_t;

	typedef struct {
		logic [GhostW-1:0] ghost;
		logic hit;
	} blank_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = RegChildMinX;
	logic [CoordW-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [3*CoordW+GhostW-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	amr_cell_overlap_blank_marker #(
		.BLANK_BIT(BLANK_POS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// corners waiting to be sent, and blanking verdicts waiting to come out
	corner_t corner_q[$];
	blank_result_t blank_expect_q[$];
	corner_t cur_corner;

	// shadow of the child box and mode registers
	longint child_lo_x = 0, child_hi_x = 0;
	longint child_lo_y = 0, child_hi_y = 0;
	longint child_lo_z = 0, child_hi_z = 0;
	bit vol_mode = 1'b0;
	bit clear_mark = 1'b0;

	// running bounding box of the current cell
	longint box_lo_x = 64'sd2147483647, box_hi_x = -64'sd2147483648;
	longint box_lo_y = 64'sd2147483647, box_hi_y = -64'sd2147483648;
	longint box_lo_z = 64'sd2147483647, box_hi_z = -64'sd2147483648;

	int unsigned mismatch_cnt = 0;
	int unsigned corners_sent = 0;
	int unsigned cells_checked = 0;
	int unsigned hits_seen = 0;
	int unsigned setups_run = 0;
	int unsigned cycle_cnt = 0;
	int unsigned send_gap = 0;
	int unsigned stall_cnt = 0;
	bit calm = 1'b0;

	task automatic flag_mismatch(input string what);
		$display("mismatch @%0d: %s", cycle_cnt, what);
		mismatch_cnt++;
	endtask

	function automatic logic [CoordW-1:0] axis_len(input longint lo, input longint hi);
		if (hi < lo)
			return '0;
		return CoordW'(hi - lo);
	endfunction

	// grows the cell box and, on the final corner, predicts the ghost byte update
	function automatic void fold_corner(input corner_t c);
		longint px, py, pz;
		logic [CoordW-1:0] ox, oy, oz, cx, cy, cz;
		logic [MeasW-1:0] ov, ce;
		logic hit;
		logic [GhostW-1:0] g;
		blank_result_t r;
		px = longint'($signed(c.x));
		py = longint'($signed(c.y));
		pz = longint'($signed(c.z));
		if (px < box_lo_x) box_lo_x = px;
		if (px > box_hi_x) box_hi_x = px;
		if (py < box_lo_y) box_lo_y = py;
		if (py > box_hi_y) box_hi_y = py;
		if (pz < box_lo_z) box_lo_z = pz;
		if (pz > box_hi_z) box_hi_z = pz;
		if (!c.last)
			return;
		ox = axis_len(box_lo_x > child_lo_x ? box_lo_x : child_lo_x,
			box_hi_x < child_hi_x ? box_hi_x : child_hi_x);
		oy = axis_len(box_lo_y > child_lo_y ? box_lo_y : child_lo_y,
			box_hi_y < child_hi_y ? box_hi_y : child_hi_y);
		oz = axis_len(box_lo_z > child_lo_z ? box_lo_z : child_lo_z,
			box_hi_z < child_hi_z ? box_hi_z : child_hi_z);
		cx = axis_len(box_lo_x, box_hi_x);
		cy = axis_len(box_lo_y, box_hi_y);
		cz = axis_len(box_lo_z, box_hi_z);
		ov = {64'd0, ox} * {64'd0, oy};
		ce = {64'd0, cx} * {64'd0, cy};
		if (vol_mode) begin
			ov = ov * {64'd0, oz};
			ce = ce * {64'd0, cz};
		end
		hit = ({ov, 1'b0} > {1'b0, ce});
		g = c.ghost;
		if (clear_mark)
			g[BLANK_POS] = 1'b0;
		if (hit)
			g[BLANK_POS] = 1'b1;
		r.ghost = g;
		r.hit = hit;
		blank_expect_q.insert(blank_expect_q.size(), r);
		box_lo_x = 64'sd2147483647;
		box_hi_x = -64'sd2147483648;
		box_lo_y = 64'sd2147483647;
		box_hi_y = -64'sd2147483648;
		box_lo_z = 64'sd2147483647;
		box_hi_z = -64'sd2147483648;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : send_blk
		corner_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				fold_corner(cur_corner);
				corners_sent++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the current transfer
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (corner_q.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 4);
				s_axis_tvalid <= 1'b0;
			end else if (corner_q.size() != 0) begin
				nxt = corner_q.pop_front();
				cur_corner <= nxt;
				s_axis_tdata <= {nxt.ghost, nxt.z, nxt.y, nxt.x};
				s_axis_tlast <= nxt.last;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : recv_blk
		blank_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (blank_expect_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result transfer %h", m_axis_tdata));
				end else begin
					want = blank_expect_q.pop_front();
					cells_checked++;
					if (want.hit)
						hits_seen++;
					if (m_axis_tdata[7:0] !== want.ghost)
						flag_mismatch($sformatf("ghost_out %h, expected %h",
							m_axis_tdata[7:0], want.ghost));
					if (m_axis_tdata[8] !== want.hit)
						flag_mismatch($sformatf("overlap_hit %b, expected %b",
							m_axis_tdata[8], want.hit));
				end
			end
			if (stall_cnt != 0) begin
				stall_cnt <= stall_cnt - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_cnt <= $urandom_range(0, 4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RegChildMinX: child_lo_x = longint'($signed(val));
			RegChildMaxX: child_hi_x = longint'($signed(val));
			RegChildMinY: child_lo_y = longint'($signed(val));
			RegChildMaxY: child_hi_y = longint'($signed(val));
			RegChildMinZ: child_lo_z = longint'($signed(val));
			RegChildMaxZ: child_hi_z = longint'($signed(val));
			RegVolumeMode: vol_mode = val[0];
			RegClearOldMark: clear_mark = val[0];
			default: ;
		endcase
	endtask

	task automatic load_setup(input logic [CoordW-1:0] mnx, input logic [CoordW-1:0] mxx,
		input logic [CoordW-1:0] mny, input logic [CoordW-1:0] mxy,
		input logic [CoordW-1:0] mnz, input logic [CoordW-1:0] mxz,
		input bit vm, input bit clr);
		write_reg(RegChildMinX, mnx);
		write_reg(RegChildMaxX, mxx);
		write_reg(RegChildMinY, mny);
		write_reg(RegChildMaxY, mxy);
		write_reg(RegChildMinZ, mnz);
		write_reg(RegChildMaxZ, mxz);
		write_reg(RegVolumeMode, {31'd0, vm});
		write_reg(RegClearOldMark, {31'd0, clr});
		setups_run++;
	endtask

	function automatic void add_corner(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
		input logic [CoordW-1:0] z, input logic [GhostW-1:0] g, input logic last);
		corner_t c;
		c.x = x;
		c.y = y;
		c.z = z;
		c.ghost = g;
		c.last = last;
		corner_q.insert(corner_q.size(), c);
	endfunction

	function automatic logic [CoordW-1:0] pick_coord(input int unsigned reach, input bit wild);
		if (wild)
			return $urandom;
		return CoordW'(longint'($urandom_range(0, 2 * reach)) - longint'(reach));
	endfunction

	function automatic void add_random_cell(input int unsigned reach);
		int unsigned n;
		bit wild;
		wild = ($urandom_range(0, 6) == 0);
		n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
		for (int unsigned i = 0; i < n; i++)
			add_corner(pick_coord(reach, wild), pick_coord(reach, wild),
				pick_coord(reach, wild), GhostW'($urandom), i == n - 1);
	endfunction

	// let all queued corners go through and the block settle before new settings
	task automatic drain();
		while (corner_q.size() != 0 || s_axis_tvalid || blank_expect_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stim_blk
		int unsigned reach;
		int unsigned reach_tab[5];
		logic [CoordW-1:0] mn[3];
		logic [CoordW-1:0] mx[3];
		reach_tab = '{4, 300, 32'h0001_0000, 32'h0100_0000, 32'h4000_0000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// exact half, just above half, single corner, disjoint, full range cell
		load_setup(32'd0, 32'd2, 32'd0, 32'd2, 32'd0, 32'd0, 1'b0, 1'b0);
		add_corner(32'd0, 32'd0, 32'd0, 8'h00, 1'b0);
		add_corner(32'd4, 32'd2, 32'd7, 8'hFF, 1'b1);
		add_corner(32'd0, 32'd0, 32'd0, 8'h00, 1'b0);
		add_corner(32'd3, 32'd2, 32'd0, 8'h00, 1'b1);
		add_corner(32'd1, 32'd1, 32'd1, 8'h08, 1'b1);
		add_corner(32'd10, 32'd10, 32'd0, 8'h55, 1'b0);
		add_corner(32'd20, 32'd20, 32'd0, 8'h5D, 1'b1);
		add_corner(CoordMin, CoordMin, CoordMin, 8'h00, 1'b0);
		add_corner(CoordMax, CoordMax, CoordMax, 8'hA5, 1'b1);
		drain();

		// whole coordinate range as child, widest volume products
		load_setup(CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, 1'b1, 1'b1);
		add_corner(CoordMin, CoordMin, CoordMin, 8'h00, 1'b0);
		add_corner(CoordMax, CoordMax, CoordMax, 8'hF7, 1'b1);
		add_corner(32'd5, 32'd5, CoordMin, 8'h00, 1'b0);
		add_corner(32'd6, 32'd6, CoordMax, 8'h08, 1'b1);
		drain();

		// child with inverted z bounds: empty in volume mode, ignored in area mode
		load_setup(CoordMin, CoordMax, CoordMin, CoordMax, 32'd5, -32'sd5, 1'b1, 1'b1);
		add_corner(32'd0, 32'd0, -32'sd10, 8'h00, 1'b0);
		add_corner(32'd4, 32'd4, 32'd10, 8'h08, 1'b1);
		drain();
		load_setup(CoordMin, CoordMax, CoordMin, CoordMax, 32'd5, -32'sd5, 1'b0, 1'b1);
		add_corner(32'd0, 32'd0, -32'sd10, 8'h00, 1'b0);
		add_corner(32'd4, 32'd4, 32'd10, 8'hFF, 1'b1);
		add_corner(32'd3, 32'd0, 32'd0, 8'h00, 1'b0);
		add_corner(32'd3, 32'd9, 32'd0, 8'h0F, 1'b1);
		drain();

		for (int unsigned ph = 0; ph < 20; ph++) begin
			reach = reach_tab[ph % 5];
			for (int k = 0; k < 3; k++) begin
				if (ph % 6 == 5) begin
					mn[k] = CoordMin;
					mx[k] = CoordMax;
				end else if (ph % 7 == 3 && k == ph % 3) begin
					mx[k] = pick_coord(reach, 1'b0);
					mn[k] = CoordW'(longint'($signed(mx[k])) + 1);
				end else begin
					mn[k] = CoordW'(-longint'($urandom_range(0, reach)));
					mx[k] = CoordW'(longint'($urandom_range(0, reach)));
				end
			end
			if (ph >= 17)
				calm = 1'b1;
			load_setup(mn[0], mx[0], mn[1], mx[1], mn[2], mx[2], ph[0], ph[1]);
			for (int unsigned c = 0; c < 15; c++)
				add_random_cell(reach);
			drain();
		end

		$display("run covered %0d corner points over %0d setups", corners_sent, setups_run);
		$display("%0d cell verdicts checked, %0d of them blanked", cells_checked, hits_seen);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> amr_cell_overlap_blank_marker.f
+incdir+design
design/acobm_pkg.sv
design/amr_cell_overlap_blank_marker.sv
bench/tb_top.sv
